// ===== design/sbks_pkg.sv =====
// sbks_pkg: shared types and codes for the shared-store stack block.
// No dependencies; used by sbks_ctrl, sbks_dp and the top level.
package sbks_pkg;

    // opcode values
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic capture;  // latch beat, read stack top
        logic fetch;    // read link and data stores
        logic commit;   // update stores, load result
    } sbks_ctl_t;

endpackage

// ===== design/shared_buffer_k_stacks_unit.sv =====
// shared_buffer_k_stacks_unit: STACKS LIFO stacks sharing one entry store.
// Flow: the result is registered after the top read, the link/data read and the
// write-back (one store port each); a new command waits until the last is done.
// A stalled result holds the write-back cycle until the result slot frees.
// Reset: async, active low; stacks empty, free list over all entries, no
// clearing pass (a fill mark stands in for the reset link chain).
module shared_buffer_k_stacks_unit
#(
    parameter int ENTRIES   = 64,
    parameter int STACKS    = 4,
    parameter int DATA_BITS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    // command channel
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  logic               opcode,
    input  logic [1:0]         stack_id,
    input  logic signed [31:0] value,
    // response channel
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [1:0]         status,
    output logic signed [31:0] popped_value,
    output logic               store_full,
    output logic               stack_empty
);

    // controller drives the three steps of each beat; the datapath
    // holds all stores and the result payload registers
    sbks_pkg::sbks_ctl_t ctl;

    sbks_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .ctl       (ctl)
    );

    sbks_dp
    #(
        .ENTRIES   (ENTRIES),
        .STACKS    (STACKS),
        .DATA_BITS (DATA_BITS)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .opcode       (opcode),
        .stack_id     (stack_id),
        .value        (value),
        .status       (status),
        .popped_value (popped_value),
        .store_full   (store_full),
        .stack_empty  (stack_empty)
    );

endmodule

// ===== design/sbks_ctrl.sv =====
// sbks_ctrl: sequencing state machine for one operation at a time.
// Depends on sbks_pkg (sbks_ctl_t).
module sbks_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output sbks_pkg::sbks_ctl_t ctl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC
    } state_t;

    state_t state_reg;
    logic   rsp_valid_reg;

    assign cmd_stall   = (state_reg != S_IDLE);
    assign rsp_valid   = rsp_valid_reg;

    assign ctl.capture = (state_reg == S_IDLE) && cmd_valid;
    assign ctl.fetch   = (state_reg == S_FETCH);
    // result slot must be free before committing
    assign ctl.commit  = (state_reg == S_EXEC) && (!rsp_valid_reg || !rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        state_reg <= S_FETCH;
                    end
                end
                S_FETCH:
                begin
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    if (ctl.commit)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (ctl.commit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== design/sbks_dp.sv =====
// sbks_dp: entry data/link stores, stack top store, free list head and
// result registers. Depends on sbks_pkg (codes, sbks_ctl_t).
module sbks_dp
#(
    parameter int ENTRIES   = 64,
    parameter int STACKS    = 4,
    parameter int DATA_BITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  sbks_pkg::sbks_ctl_t ctl,
    input  logic                opcode,
    input  logic [1:0]          stack_id,
    input  logic signed [31:0]  value,
    output logic [1:0]          status,
    output logic signed [31:0]  popped_value,
    output logic                store_full,
    output logic                stack_empty
);

    localparam int LW        = $clog2(ENTRIES + 1);          // link code, null = ENTRIES
    localparam int AW        = $clog2(ENTRIES);
    localparam int SW        = (STACKS > 1) ? $clog2(STACKS) : 1;
    localparam int STK_DEPTH = 1 << SW;
    localparam logic [LW-1:0] NULL_LINK = LW'(ENTRIES);

    // stores
    logic [DATA_BITS-1:0] data_mem [ENTRIES];
    logic [LW-1:0]        link_mem [ENTRIES];
    logic [LW-1:0]        top_mem  [STK_DEPTH];
    logic [STK_DEPTH-1:0] top_vld_reg;

    // operation registers
    logic                 op_reg;
    logic [1:0]           sid_reg;
    logic [DATA_BITS-1:0] val_reg;
    logic [LW-1:0]        top_rd_reg;
    logic                 top_vld_rd_reg;
    logic [LW-1:0]        link_rd_reg;
    logic [DATA_BITS-1:0] data_rd_reg;
    logic [LW-1:0]        la_reg;
    logic                 fresh_reg;
    logic [LW-1:0]        free_head_reg;
    logic [LW-1:0]        fill_reg;

    // result registers
    logic [1:0]           status_reg;
    logic [31:0]          popped_reg;
    logic                 full_reg;
    logic                 empty_reg;

    logic [63:0]          val_wide;
    logic [63:0]          data_wide;
    logic [6:0]           sid_w;
    logic [SW-1:0]        cap_addr;
    logic [SW-1:0]        sid_addr;
    logic                 sid_ok;
    logic [LW-1:0]        top_cur;
    logic [LW-1:0]        la;
    logic [LW-1:0]        link_cur;
    logic                 push_ok;
    logic                 pop_ok;
    logic [LW-1:0]        free_head_next;
    logic [LW-1:0]        top_after;
    logic [1:0]           status_next;
    logic [31:0]          popped_next;

    always_comb
    begin
        val_wide                = '0;
        val_wide[31:0]          = value;
        data_wide               = '0;
        data_wide[DATA_BITS-1:0] = data_rd_reg;
    end

    assign sid_w    = 7'(stack_id);
    assign cap_addr = sid_w[SW-1:0];
    assign sid_addr = 7'(sid_reg) < 7'(STACKS) ? SW'(sid_reg) : '0;
    assign sid_ok   = 7'(sid_reg) < 7'(STACKS);

    assign top_cur  = top_vld_rd_reg ? top_rd_reg : NULL_LINK;
    assign la       = (op_reg == sbks_pkg::OP_POP) ? top_cur : free_head_reg;
    // entries at or above the fill mark still hold their reset link i+1
    assign link_cur = fresh_reg ? LW'(la_reg + 1'b1) : link_rd_reg;

    assign push_ok  = (op_reg == sbks_pkg::OP_PUSH) && sid_ok && (free_head_reg < NULL_LINK);
    assign pop_ok   = (op_reg == sbks_pkg::OP_POP) && sid_ok && (top_cur < NULL_LINK);

    always_comb
    begin
        free_head_next = free_head_reg;
        top_after      = top_cur;
        status_next    = sbks_pkg::ST_OK;
        popped_next    = '0;
        if (push_ok)
        begin
            free_head_next = link_cur;
            top_after      = free_head_reg;
        end
        else if (pop_ok)
        begin
            free_head_next = top_cur;
            top_after      = link_cur;
            popped_next    = data_wide[31:0];
        end
        else if (op_reg == sbks_pkg::OP_PUSH)
        begin
            status_next = sbks_pkg::ST_FULL;
        end
        else
        begin
            status_next = sbks_pkg::ST_EMPTY;
        end
    end

    // capture and store reads
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            op_reg     <= opcode;
            sid_reg    <= stack_id;
            val_reg    <= val_wide[DATA_BITS-1:0];
            top_rd_reg <= top_mem[cap_addr];
        end
        if (ctl.fetch)
        begin
            la_reg      <= la;
            fresh_reg   <= (la >= fill_reg);
            link_rd_reg <= link_mem[la[AW-1:0]];
            data_rd_reg <= data_mem[top_cur[AW-1:0]];
        end
    end

    // store writes
    always_ff @(posedge clk)
    begin
        if (ctl.commit && push_ok)
        begin
            data_mem[free_head_reg[AW-1:0]] <= val_reg;
            link_mem[free_head_reg[AW-1:0]] <= top_cur;
            top_mem[sid_addr]               <= free_head_reg;
        end
        else if (ctl.commit && pop_ok)
        begin
            link_mem[top_cur[AW-1:0]] <= free_head_reg;
            top_mem[sid_addr]         <= link_cur;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            status_reg <= status_next;
            popped_reg <= popped_next;
            full_reg   <= !(free_head_next < NULL_LINK);
            empty_reg  <= !sid_ok || !(top_after < NULL_LINK);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_vld_reg    <= '0;
            top_vld_rd_reg <= 1'b0;
            free_head_reg  <= '0;
            fill_reg       <= '0;
        end
        else
        begin
            if (ctl.capture)
            begin
                top_vld_rd_reg <= top_vld_reg[cap_addr];
            end
            if (ctl.commit && (push_ok || pop_ok))
            begin
                top_vld_reg[sid_addr] <= 1'b1;
                free_head_reg         <= free_head_next;
            end
            if (ctl.commit && push_ok && fresh_reg)
            begin
                fill_reg <= LW'(free_head_reg + 1'b1);
            end
        end
    end

    assign status       = status_reg;
    assign popped_value = popped_reg;
    assign store_full   = full_reg;
    assign stack_empty  = empty_reg;

endmodule
